### rtl/core/sorted_list_set_relation_core_defines.svh
// Assertion macros used by the core RTL.
`ifndef SORTED_LIST_SET_RELATION_CORE_DEFINES_SVH
`define SORTED_LIST_SET_RELATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SLSR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SLSR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/slsr_pkg.sv
package slsr_pkg;

   localparam int KEY_W = 64;

   localparam logic [1:0] OP_CLEAR       = 2'd0;
   localparam logic [1:0] OP_APPEND_ATTR = 2'd1;
   localparam logic [1:0] OP_APPEND_EXPR = 2'd2;
   localparam logic [1:0] OP_EVALUATE    = 2'd3;

   localparam logic [1:0] MODE_ONE_OF   = 2'd0;
   localparam logic [1:0] MODE_NONE_OF  = 2'd1;
   localparam logic [1:0] MODE_ALL_OF   = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   typedef struct packed {
      logic       start;
      logic       defined;
      logic [1:0] mode;
      logic       out_free;
   } slsr_walk_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic verdict;
   } slsr_walk_rsp_type;

endpackage

### rtl/core/sorted_list_set_relation_core.sv
// Sorted-list set relation core. Loads an attribute list and an expression
// list of 64-bit signed keys (ascending, no duplicates) into two key RAMs and,
// on an evaluate transaction, merges them to give one verdict: any common key
// (one_of), no common key (none_of) or expression list contained in the
// attribute list (all_of); an undefined attribute or the reserved mode always
// gives 0. Clear and append transactions may follow back to back; an append
// to a full list is dropped and raises overflowed until the next clear. An
// evaluate runs one merge step per cycle, its last step held while a result
// waits, at least one step and at most attr_count + expr_count steps, paced
// by the single read port of each key RAM (registered read data, addresses
// issued a step ahead). No request is taken during an evaluate; the result
// sits in an output register, so clears and appends proceed while it waits on
// rsp_ready. A further evaluate holds on its last step until the waiting result
// is taken. The user must write relation_mode through the csr port only while
// the core is idle; the core does not enforce it. No clearing pass after reset.
module sorted_list_set_relation_core import slsr_pkg::*; #(
   parameter int LIST_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_opcode,
   input  logic signed [KEY_W-1:0] req_key_value,
   input  logic                    req_attr_defined,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_match,
   output logic                    rsp_overflowed,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_relation_mode
);

   `include "sorted_list_set_relation_core_defines.svh"

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic [1:0]    mode_ff;
   logic [CW-1:0] attr_cnt_ff, expr_cnt_ff;
   logic          ovf_ff;
   logic          rsp_valid_ff, rsp_match_ff, rsp_ovf_ff;

   logic req_fire, attr_full, expr_full, attr_wr, expr_wr;
   logic [KEY_W-1:0] attr_data, expr_data;
   logic [AW-1:0]    attr_rd_addr, expr_rd_addr;

   slsr_walk_cmd_type walk_cmd;
   slsr_walk_rsp_type walk_rsp;

   assign req_ready = !walk_rsp.busy;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign attr_full = (attr_cnt_ff == CW'(LIST_DEPTH));
   assign expr_full = (expr_cnt_ff == CW'(LIST_DEPTH));
   assign attr_wr   = req_fire && (req_opcode == OP_APPEND_ATTR) && !attr_full;
   assign expr_wr   = req_fire && (req_opcode == OP_APPEND_EXPR) && !expr_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_ONE_OF;
         attr_cnt_ff <= '0;
         expr_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_relation_mode;
         end
         if (req_fire) begin
            case (req_opcode)
               OP_CLEAR: begin
                  attr_cnt_ff <= '0;
                  expr_cnt_ff <= '0;
                  ovf_ff      <= 1'b0;
               end
               OP_APPEND_ATTR: begin
                  if (attr_full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     attr_cnt_ff <= attr_cnt_ff + CW'(1);
                  end
               end
               OP_APPEND_EXPR: begin
                  if (expr_full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     expr_cnt_ff <= expr_cnt_ff + CW'(1);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   slsr_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_wr),
      .wr_addr (attr_cnt_ff[AW-1:0]),
      .wr_data (req_key_value),
      .rd_addr (attr_rd_addr),
      .rd_data (attr_data)
   );

   slsr_ram #(.WIDTH(KEY_W), .DEPTH(LIST_DEPTH)) u_expr_ram (
      .clock   (clock),
      .wr_en   (expr_wr),
      .wr_addr (expr_cnt_ff[AW-1:0]),
      .wr_data (req_key_value),
      .rd_addr (expr_rd_addr),
      .rd_data (expr_data)
   );

   assign walk_cmd.start    = req_fire && (req_opcode == OP_EVALUATE);
   assign walk_cmd.defined  = req_attr_defined;
   assign walk_cmd.mode     = mode_ff;
   assign walk_cmd.out_free = !rsp_valid_ff || rsp_ready;

   slsr_walk #(.LIST_DEPTH(LIST_DEPTH)) u_walk (
      .clock        (clock),
      .reset        (reset),
      .cmd          (walk_cmd),
      .attr_cnt     (attr_cnt_ff),
      .expr_cnt     (expr_cnt_ff),
      .attr_data    (attr_data),
      .expr_data    (expr_data),
      .attr_rd_addr (attr_rd_addr),
      .expr_rd_addr (expr_rd_addr),
      .rsp          (walk_rsp)
   );

   // load the output register on a finished walk, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (walk_rsp.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (walk_rsp.done) begin
         rsp_match_ff <= walk_rsp.verdict;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match      = rsp_match_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   `SLSR_ASSERT_NXT(a_full_append_flags, clock, reset,
      req_fire && (req_opcode == OP_APPEND_ATTR) && attr_full, ovf_ff,
      "dropped append did not raise overflow")
   `SLSR_ASSERT_NXT(a_eval_blocks, clock, reset, walk_cmd.start, !req_ready,
      "evaluate did not block the request channel")
   `SLSR_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1,
      (attr_cnt_ff <= CW'(LIST_DEPTH)) && (expr_cnt_ff <= CW'(LIST_DEPTH)),
      "list count beyond depth")
   `SLSR_ASSERT_IMP(a_done_free, clock, reset, walk_rsp.done,
      !rsp_valid_ff || rsp_ready, "result overwrote a pending transaction")

endmodule

### rtl/core/slsr_ram.sv
module slsr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/slsr_walk.sv
module slsr_walk import slsr_pkg::*; #(
   parameter int LIST_DEPTH = 64
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  slsr_walk_cmd_type                                 cmd,
   input  logic [$clog2(LIST_DEPTH+1)-1:0]                   attr_cnt,
   input  logic [$clog2(LIST_DEPTH+1)-1:0]                   expr_cnt,
   input  logic [KEY_W-1:0]                                  attr_data,
   input  logic [KEY_W-1:0]                                  expr_data,
   output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] attr_rd_addr,
   output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] expr_rd_addr,
   output slsr_walk_rsp_type                                 rsp
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   localparam logic WS_IDLE = 1'b0;
   localparam logic WS_WALK = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic          early_ff, early_in;

   logic a_end, e_end, keys_eq, key_lt;
   logic step_done, share, subset, verdict;

   assign a_end   = (i_ff >= attr_cnt);
   assign e_end   = (j_ff >= expr_cnt);
   assign keys_eq = (attr_data == expr_data);
   assign key_lt  = ($signed(attr_data) < $signed(expr_data));

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      early_in  = early_ff;
      step_done = 1'b0;
      share     = 1'b0;
      subset    = 1'b0;
      verdict   = 1'b0;
      case (state_ff)
         WS_IDLE: begin
            if (cmd.start) begin
               i_in     = '0;
               j_in     = '0;
               early_in = !cmd.defined || (cmd.mode == MODE_RESERVED) ||
                          ((cmd.mode == MODE_ALL_OF) && (expr_cnt > attr_cnt));
               state_in = WS_WALK;
            end
         end
         WS_WALK: begin
            if (early_ff) begin
               step_done = 1'b1;
            end else if (cmd.mode == MODE_ALL_OF) begin
               if (e_end) begin
                  step_done = 1'b1;
                  subset    = 1'b1;
               end else if (a_end) begin
                  step_done = 1'b1;
               end else if (key_lt) begin
                  i_in = i_ff + CW'(1);
               end else if (keys_eq) begin
                  i_in = i_ff + CW'(1);
                  j_in = j_ff + CW'(1);
               end else begin
                  step_done = 1'b1;
               end
            end else begin
               if (a_end || e_end) begin
                  step_done = 1'b1;
               end else if (keys_eq) begin
                  step_done = 1'b1;
                  share     = 1'b1;
               end else if (key_lt) begin
                  i_in = i_ff + CW'(1);
               end else begin
                  j_in = j_ff + CW'(1);
               end
            end
            case (cmd.mode)
               MODE_ONE_OF:  verdict = share;
               MODE_NONE_OF: verdict = !share;
               MODE_ALL_OF:  verdict = subset;
               default:      verdict = 1'b0;
            endcase
            if (early_ff) begin
               verdict = 1'b0;
            end
            // hold on the final step until the output register is free
            if (step_done && cmd.out_free) begin
               state_in = WS_IDLE;
            end
         end
         default: state_in = WS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      early_ff <= early_in;
   end

   // read ahead at the next indices so data lines up with the next step
   assign attr_rd_addr = i_in[AW-1:0];
   assign expr_rd_addr = j_in[AW-1:0];

   assign rsp.busy    = (state_ff == WS_WALK);
   assign rsp.done    = (state_ff == WS_WALK) && step_done && cmd.out_free;
   assign rsp.verdict = verdict;

endmodule
